[design/htt_pkg.sv]
// ----------------------------------------------------------------------------
// Hashed transposition table: shared package
// Table geometry, entry layout, bound flag codes, the Zobrist word ROM and
// the command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package htt_pkg;

  // Table geometry: direct-mapped, indexed by the low hash bits.
  localparam int TABLE_INDEX_BITS = 10;
  localparam int TABLE_ENTRIES    = 1 << TABLE_INDEX_BITS;

  // Field widths.
  localparam int BOARD_W = 64;
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 7;
  localparam int SCORE_W = 21;
  localparam int MOVE_W  = 7;
  localparam int FLAG_W  = 2;

  // Stream widths, packed from the lowest bit up and padded to whole bytes.
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 32;

  // Entry info layout: score, move, depth, flag.
  localparam int INFO_W    = SCORE_W + MOVE_W + DEPTH_W + FLAG_W;
  localparam int ENTRY_W   = 1 + KEY_W + INFO_W;

  // Bound flag codes.
  localparam logic [FLAG_W-1:0] FLAG_EXACT = 2'd0;
  localparam logic [FLAG_W-1:0] FLAG_ALPHA = 2'd1;
  localparam logic [FLAG_W-1:0] FLAG_BETA  = 2'd2;

  // Operation codes carried on tuser.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  // Move code for "no move".
  localparam logic [MOVE_W-1:0] MOVE_NONE = 7'h7F;

  // Zobrist word ROM: xorshift64 with shifts 13, 7 and 17.
  localparam int          HASH_WORD_COUNT = 2 * BOARD_W;
  localparam logic [63:0] HASH_SEED       = 64'd88172645463325252;

  typedef logic [HASH_WORD_COUNT-1:0][KEY_W-1:0] hash_words_t;

  function automatic hash_words_t gen_hash_words();
    logic [63:0] s;
    hash_words_t w;
    s = HASH_SEED;
    for (int i = 0; i < HASH_WORD_COUNT; i++) begin
      s = s ^ (s << 13);
      s = s ^ (s >> 7);
      s = s ^ (s << 17);
      w[i] = s;
    end
    return w;
  endfunction

  localparam hash_words_t HASH_WORDS = gen_hash_words();

  // Zobrist hash: word 2i for a player stone on square i, 2i+1 for the
  // opponent. Each key bit is a parity over a fixed subset of board bits.
  function automatic logic [KEY_W-1:0] zobrist_hash(input logic [BOARD_W-1:0] pb,
                                                     input logic [BOARD_W-1:0] ob);
    logic [KEY_W-1:0] h;
    h = '0;
    for (int i = 0; i < BOARD_W; i++) begin
      if (pb[i]) h = h ^ HASH_WORDS[2*i];
      if (ob[i]) h = h ^ HASH_WORDS[2*i+1];
    end
    return h;
  endfunction

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;   // write one empty entry of the clearing pass
    logic load;    // capture the accepted beat and its hash
    logic read;    // read the entry picked by the captured hash
    logic finish;  // write back a store or register a lookup result
  } htt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;  // clearing pass is on its last entry
    logic is_store;    // captured item is a store
    logic out_free;    // output register can take a result this cycle
  } htt_status_t;

endpackage

[design/htt_ctrl.sv]
// ----------------------------------------------------------------------------
// Hashed transposition table: controller
// Sequences the clearing pass after reset, then for each item a table read
// followed by the decide step that writes back a store or emits a result.
// ----------------------------------------------------------------------------
module htt_ctrl
  import htt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  htt_status_t status,
  output htt_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DECIDE
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_finish;
  logic   accept;

  // The decide step completes unless a lookup result finds the output full.
  assign can_finish = status.is_store || status.out_free;

  // A new item enters when idle or as the current one completes.
  assign s_tready = (state == S_IDLE) || ((state == S_DECIDE) && can_finish);
  assign accept   = s_tvalid && s_tready;

  // Commands to the datapath.
  assign cmd.clear  = (state == S_CLEAR);
  assign cmd.load   = accept;
  assign cmd.read   = (state == S_READ);
  assign cmd.finish = (state == S_DECIDE) && can_finish;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (can_finish) state_next = accept ? S_READ : S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/htt_datapath.sv]
// ----------------------------------------------------------------------------
// Hashed transposition table: datapath
// Hashes the boards on entry, holds the item, owns the single-port entry
// memory and its clearing counter, and makes the store and lookup decisions.
// ----------------------------------------------------------------------------
module htt_datapath
  import htt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  htt_cmd_t              cmd,
  output htt_status_t           status,
  input  logic                  s_tuser,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // Captured item.
  logic                      op_r;
  logic [KEY_W-1:0]          key_r;
  logic [DEPTH_W-1:0]        depth_r;
  logic signed [SCORE_W-1:0] alpha_r;
  logic signed [SCORE_W-1:0] beta_r;
  logic signed [SCORE_W-1:0] score_r;
  logic [MOVE_W-1:0]         move_r;

  // Entry memory; the top bit of an entry marks it as written.
  logic [ENTRY_W-1:0]          mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0]          rd_data;
  logic [TABLE_INDEX_BITS-1:0] clr_cnt;
  logic [TABLE_INDEX_BITS-1:0] idx;
  logic [TABLE_INDEX_BITS-1:0] wr_addr;
  logic [ENTRY_W-1:0]          wr_data;
  logic                        wr_en;

  // Fields of the entry just read.
  logic                      e_valid;
  logic [KEY_W-1:0]          e_key;
  logic signed [SCORE_W-1:0] e_score;
  logic [MOVE_W-1:0]         e_move;
  logic [DEPTH_W-1:0]        e_depth;
  logic [FLAG_W-1:0]         e_flag;

  // Decision results.
  logic                      match;
  logic                      do_write;
  logic [FLAG_W-1:0]         new_flag;
  logic                      hit;
  logic [SCORE_W-1:0]        hit_score;

  // Output register.
  logic                      out_valid;
  logic                      out_hit;
  logic [SCORE_W-1:0]        out_score;
  logic                      out_match;
  logic [MOVE_W-1:0]         out_move;

  // Capture the beat; the hash is formed straight from the incoming boards.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= s_tuser;
      key_r   <= zobrist_hash(s_tdata[63:0], s_tdata[127:64]);
      depth_r <= s_tdata[134:128];
      alpha_r <= s_tdata[155:135];
      beta_r  <= s_tdata[176:156];
      score_r <= s_tdata[197:177];
      move_r  <= s_tdata[204:198];
    end
  end

  assign idx = key_r[TABLE_INDEX_BITS-1:0];

  // Clearing pass counter after reset, stepped by each clear command.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Split the entry that was read.
  assign e_valid = rd_data[ENTRY_W-1];
  assign e_key   = rd_data[INFO_W +: KEY_W];
  assign e_score = rd_data[0 +: SCORE_W];
  assign e_move  = rd_data[SCORE_W +: MOVE_W];
  assign e_depth = rd_data[SCORE_W+MOVE_W +: DEPTH_W];
  assign e_flag  = rd_data[SCORE_W+MOVE_W+DEPTH_W +: FLAG_W];

  assign match = e_valid && (e_key == key_r);

  // Store: replace unless a matching entry holds a deeper result.
  assign do_write = !match || (depth_r >= e_depth);

  // Store: classify the score against the window, alpha side first.
  always_comb begin
    if (score_r <= alpha_r) begin
      new_flag = FLAG_ALPHA;
    end else if (score_r >= beta_r) begin
      new_flag = FLAG_BETA;
    end else begin
      new_flag = FLAG_EXACT;
    end
  end

  // Lookup: decide whether the entry settles the query.
  always_comb begin
    hit       = 1'b0;
    hit_score = '0;
    if (match && (e_depth >= depth_r)) begin
      if (e_flag == FLAG_EXACT) begin
        hit       = 1'b1;
        hit_score = e_score;
      end else if ((e_flag == FLAG_ALPHA) && (e_score <= alpha_r)) begin
        hit       = 1'b1;
        hit_score = alpha_r;
      end else if ((e_flag == FLAG_BETA) && (e_score >= beta_r)) begin
        hit       = 1'b1;
        hit_score = beta_r;
      end
    end
  end

  // Memory write port: clearing pass or store write-back.
  assign wr_en   = cmd.clear || (cmd.finish && (op_r == OP_STORE) && do_write);
  assign wr_addr = cmd.clear ? clr_cnt : idx;
  assign wr_data = cmd.clear ? '0
                             : {1'b1, key_r, new_flag, depth_r, move_r, score_r};

  // Single-port memory with a registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read) begin
      rd_data <= mem[idx];
    end
  end

  // Output register: filled by a finished lookup, freed when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && (op_r == OP_LOOKUP)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && (op_r == OP_LOOKUP)) begin
      out_hit   <= hit;
      out_score <= hit_score;
      out_match <= match;
      out_move  <= match ? e_move : MOVE_NONE;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_move, out_match, out_score, out_hit};

  // Status to the controller.
  assign status.clear_last = &clr_cnt;
  assign status.is_store   = (op_r == OP_STORE);
  assign status.out_free   = !out_valid || m_tready;

endmodule

[design/hashed_transposition_table_unit.sv]
// ----------------------------------------------------------------------------
// Hashed transposition table unit
// Direct-mapped Zobrist transposition table with its board hash unit.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream: tuser is the operation (lookup or store) and
// tdata carries the two boards, depth, window, score and move. A lookup gives
// one beat on the m_ stream with hit, score, key match and stored move; a
// store gives no beat and writes the entry back when it may replace it.
// After reset the unit runs a clearing pass over all 1024 entries, one entry
// a cycle, and holds s_tready low until the pass is done.
// Each item takes a read of the single-port entry memory, then a decide
// cycle that writes back a store or registers a lookup result. A new beat
// can be taken in the decide cycle, so the next item's read can follow it.
// A lookup result is registered in its decide cycle and then shows on m_tvalid.
// When the receiver stalls, the result stays in the output register and the
// next item is still taken and read; a following lookup waits in its decide
// cycle until the register frees, while a store completes regardless.
// ----------------------------------------------------------------------------
module hashed_transposition_table_unit
  import htt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: player_board, opponent_board, search_depth, alpha_bound,
  //        beta_bound, score_in, move_in, zero padding
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // tuser: opcode
  input  logic                  s_tuser,
  // Output stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata: hit, score_out, key_match, move_out, zero padding
  output logic [OUT_DATA_W-1:0] m_tdata
);

  htt_cmd_t    cmd;
  htt_status_t status;

  // Sequencer.
  htt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hash, table memory and decisions.
  htt_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[tb/tb_hashed_transposition_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed transposition table unit: testbench
// Sends lookup and store beats and checks every lookup result, field by
// field, against the expectation in its directed row or else a predictor
// of its own, which keeps its own copy of the Zobrist words and the table.
// A short directed list covers the empty entry, equal and deeper depths,
// every bound flag, an inverted window, the score and depth extremes and
// an index collision. A random part follows, built mostly from a small
// pool of positions so that keys match and entries get evicted. Both sides
// idle at random, and once the receiver holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_hashed_transposition_table_unit;
  import htt_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SCORE_MIN    = -1048576;
  localparam int SCORE_MAX    = 1048575;

  // One input item and one lookup result.
  typedef struct {
    logic                op;
    logic [63:0]         pb;
    logic [63:0]         ob;
    logic [6:0]          depth;
    logic signed [20:0]  alpha;
    logic signed [20:0]  beta;
    logic signed [20:0]  score;
    logic [6:0]          move;
  } tt_req_t;

  typedef struct {
    logic                hit;
    logic signed [20:0]  score;
    logic                key_match;
    logic [6:0]          move;
  } tt_resp_t;

  typedef struct {
    tt_req_t  req;
    bit       typed;
    tt_resp_t want;
  } dir_row_t;

  typedef struct {
    logic [63:0] pb;
    logic [63:0] ob;
  } bp_t;

  // Predicted table entry.
  typedef struct packed {
    logic [1:0]  flag;
    logic [6:0]  depth;
    logic [6:0]  move;
    logic [20:0] score;
  } slot_info_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Predictor state.
  logic [63:0] zwords [128];
  logic [63:0] tt_key [TABLE_ENTRIES];
  slot_info_t  tt_info [TABLE_ENTRIES];
  bit          tt_valid [TABLE_ENTRIES];
  tt_resp_t    lookup_expect_q [$];

  // Run statistics.
  int fail_count;
  int cycle_count;
  int items_sent;
  int lookups_sent;
  int stores_sent;
  int beats_taken;
  int hits_seen;
  int matches_seen;
  bit pressure_done;

  hashed_transposition_table_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock and the single reset at the start.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Cycle counter and timeout.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  function automatic logic [63:0] position_key(input logic [63:0] pb,
                                               input logic [63:0] ob);
    logic [63:0] h;
    h = '0;
    for (int i = 0; i < 64; i++) begin
      if (pb[i]) h ^= zwords[2*i];
      if (ob[i]) h ^= zwords[2*i+1];
    end
    return h;
  endfunction

  function automatic tt_req_t mk_req(input logic op, input logic [63:0] pb,
                                     input logic [63:0] ob, input int depth,
                                     input int a, input int b, input int sc,
                                     input int mv);
    tt_req_t r;
    r.op    = op;
    r.pb    = pb;
    r.ob    = ob;
    r.depth = depth[6:0];
    r.alpha = a[20:0];
    r.beta  = b[20:0];
    r.score = sc[20:0];
    r.move  = mv[6:0];
    return r;
  endfunction

  function automatic tt_resp_t mk_resp(input bit hit, input int sc, input bit km,
                                       input int mv);
    tt_resp_t r;
    r.hit       = hit;
    r.score     = sc[20:0];
    r.key_match = km;
    r.move      = mv[6:0];
    return r;
  endfunction

  // Toggle the square that Zobrist word k belongs to.
  function automatic bp_t flip_word(input bp_t p, input int k);
    if (k % 2 == 0) p.pb[k/2] = ~p.pb[k/2];
    else p.ob[k/2] = ~p.ob[k/2];
    return p;
  endfunction

  // Apply one item to the predicted table; a lookup yields one result.
  task automatic apply_to_table(input tt_req_t r, output bit has_resp,
                                output tt_resp_t resp);
    logic [63:0]                 key;
    logic [TABLE_INDEX_BITS-1:0] idx;
    bit                          match;
    slot_info_t                  e;
    key   = position_key(r.pb, r.ob);
    idx   = key[TABLE_INDEX_BITS-1:0];
    match = tt_valid[idx] && (tt_key[idx] == key);
    e     = tt_info[idx];
    resp  = mk_resp(1'b0, 0, match, int'(MOVE_NONE));
    if (r.op == OP_STORE) begin
      has_resp = 1'b0;
      if (!match || r.depth >= e.depth) begin
        if (r.score <= r.alpha) e.flag = FLAG_ALPHA;
        else if (r.score >= r.beta) e.flag = FLAG_BETA;
        else e.flag = FLAG_EXACT;
        e.score       = r.score;
        e.move        = r.move;
        e.depth       = r.depth;
        tt_info[idx]  = e;
        tt_key[idx]   = key;
        tt_valid[idx] = 1'b1;
      end
    end else begin
      has_resp = 1'b1;
      if (match) begin
        resp.move = e.move;
        if (e.depth >= r.depth) begin
          if (e.flag == FLAG_EXACT) begin
            resp.hit   = 1'b1;
            resp.score = e.score;
          end else if (e.flag == FLAG_ALPHA && $signed(e.score) <= r.alpha) begin
            resp.hit   = 1'b1;
            resp.score = r.alpha;
          end else if (e.flag == FLAG_BETA && $signed(e.score) >= r.beta) begin
            resp.hit   = 1'b1;
            resp.score = r.beta;
          end
        end
      end
    end
  endtask

  // Offer one beat after a random gap, or none in gap-free stretches, and record what it should produce.
  task automatic offer_item(input tt_req_t r, input bit typed, input tt_resp_t want);
    int       gap;
    bit       has_resp;
    tt_resp_t resp;
    gap = (((items_sent / 100) % 4) == 2) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.op;
    s_tdata  <= {3'b000, r.move, r.score, r.beta, r.alpha, r.depth, r.ob, r.pb};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (r.op == OP_STORE) stores_sent++;
    else lookups_sent++;
    apply_to_table(r, has_resp, resp);
    if (has_resp) lookup_expect_q.push_back(typed ? want : resp);
  endtask

  // Result monitor: each beat against the oldest expectation.
  always @(posedge clk) begin
    tt_resp_t got;
    tt_resp_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.hit       = m_tdata[0];
      got.score     = m_tdata[21:1];
      got.key_match = m_tdata[22];
      got.move      = m_tdata[29:23];
      if (got.hit) hits_seen++;
      if (got.key_match) matches_seen++;
      if (lookup_expect_q.size() == 0) begin
        note_mismatch($sformatf("result beat with nothing expected, tdata %08h", m_tdata));
      end else begin
        want = lookup_expect_q.pop_front();
        if (got.hit !== want.hit)
          note_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
        if (got.score !== want.score)
          note_mismatch($sformatf("score_out %0d, expected %0d", got.score, want.score));
        if (got.key_match !== want.key_match)
          note_mismatch($sformatf("key_match %0b, expected %0b", got.key_match,
                                  want.key_match));
        if (got.move !== want.move)
          note_mismatch($sformatf("move_out %02h, expected %02h", got.move, want.move));
      end
    end
  end

  // Receiver: random stalls, stall-free stretches and one long hold-off.
  initial begin
    int stall;
    m_tready = 1'b0;
    beats_taken = 0;
    pressure_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!pressure_done && beats_taken >= 200) begin
        stall = 400;
        pressure_done = 1'b1;
      end else if (((beats_taken / 60) % 4) == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 8);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      beats_taken++;
    end
  end

  // Stimulus: directed list, then random items over a pool of positions.
  initial begin
    logic [63:0] seed_word;
    int          pair_i;
    int          pair_j;
    bp_t         pool [16];
    bp_t         pos;
    bp_t         partner;
    dir_row_t    rows [$];
    dir_row_t    row;
    tt_req_t     r;
    tt_resp_t    none;
    int          a;

    s_tvalid = 1'b0;
    s_tuser  = OP_LOOKUP;
    s_tdata  = '0;
    fail_count = 0;
    items_sent = 0;
    lookups_sent = 0;
    stores_sent = 0;
    hits_seen = 0;
    matches_seen = 0;

    // Zobrist words from the xorshift64 sequence.
    seed_word = 64'd88172645463325252;
    for (int i = 0; i < 128; i++) begin
      seed_word ^= seed_word << 13;
      seed_word ^= seed_word >> 7;
      seed_word ^= seed_word << 17;
      zwords[i] = seed_word;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) tt_valid[i] = 1'b0;

    // Two words with equal index bits give positions that share an entry.
    pair_i = 0;
    pair_j = 0;
    for (int i = 0; i < 128 && pair_j == 0; i++)
      for (int j = i + 1; j < 128 && pair_j == 0; j++)
        if (zwords[i][TABLE_INDEX_BITS-1:0] == zwords[j][TABLE_INDEX_BITS-1:0]) begin
          pair_i = i;
          pair_j = j;
        end
    partner = flip_word(flip_word('{64'd0, 64'd0}, pair_i), pair_j);

    none = mk_resp(1'b0, 0, 1'b0, 0);

    // Empty entries never match, even the all-zero key.
    rows.push_back('{mk_req(OP_LOOKUP, '0, '0, 0, 0, 0, 0, 0), 1,
                     mk_resp(0, 0, 0, int'(MOVE_NONE))});
    rows.push_back('{mk_req(OP_LOOKUP, '1, '1, 64, SCORE_MIN, SCORE_MAX, 0, 0), 1,
                     mk_resp(0, 0, 0, int'(MOVE_NONE))});
    // Exact entry, equal and deeper queries, a shallower store that is refused.
    rows.push_back('{mk_req(OP_STORE, '0, '0, 10, -100, 100, 50, 5), 0, none});
    rows.push_back('{mk_req(OP_LOOKUP, '0, '0, 10, 0, 0, 0, 0), 1, mk_resp(1, 50, 1, 5)});
    rows.push_back('{mk_req(OP_LOOKUP, '0, '0, 11, 0, 0, 0, 0), 1, mk_resp(0, 0, 1, 5)});
    rows.push_back('{mk_req(OP_STORE, '0, '0, 9, -100, 100, 70, 6), 0, none});
    rows.push_back('{mk_req(OP_LOOKUP, '0, '0, 0, 0, 0, 0, 0), 1, mk_resp(1, 50, 1, 5)});
    // Equal depth overwrites; the score lands on alpha.
    rows.push_back('{mk_req(OP_STORE, '0, '0, 10, -100, 100, -100, 63), 0, none});
    rows.push_back('{mk_req(OP_LOOKUP, '0, '0, 5, -50, 100, 0, 0), 1,
                     mk_resp(1, -50, 1, 63)});
    rows.push_back('{mk_req(OP_LOOKUP, '0, '0, 5, -200, 100, 0, 0), 1,
                     mk_resp(0, 0, 1, 63)});
    // Lower bound at a depth above 64, with no move.
    rows.push_back('{mk_req(OP_STORE, '1, '1, 127, 0, 10, 10, int'(MOVE_NONE)), 0, none});
    rows.push_back('{mk_req(OP_LOOKUP, '1, '1, 127, 0, 5, 0, 0), 1,
                     mk_resp(1, 5, 1, int'(MOVE_NONE))});
    rows.push_back('{mk_req(OP_LOOKUP, '1, '1, 127, 0, 20, 0, 0), 1,
                     mk_resp(0, 0, 1, int'(MOVE_NONE))});
    // Inverted window: alpha is tested first, then beta.
    rows.push_back('{mk_req(OP_STORE, 64'd1, '0, 3, 100, -100, 0, 1), 0, none});
    rows.push_back('{mk_req(OP_LOOKUP, 64'd1, '0, 3, 0, 0, 0, 0), 1, mk_resp(1, 0, 1, 1)});
    rows.push_back('{mk_req(OP_STORE, 64'd1, '0, 3, 100, -100, 200, 2), 0, none});
    rows.push_back('{mk_req(OP_LOOKUP, 64'd1, '0, 0, 0, 200, 0, 0), 1,
                     mk_resp(1, 200, 1, 2)});
    // Score extremes.
    rows.push_back('{mk_req(OP_STORE, '0, 64'h8000_0000_0000_0000, 64, SCORE_MIN,
                            SCORE_MAX, SCORE_MIN, 0), 0, none});
    rows.push_back('{mk_req(OP_LOOKUP, '0, 64'h8000_0000_0000_0000, 64, SCORE_MIN, 0,
                            0, 0), 1, mk_resp(1, SCORE_MIN, 1, 0)});
    rows.push_back('{mk_req(OP_STORE, '0, 64'h8000_0000_0000_0000, 64, SCORE_MIN,
                            SCORE_MAX, SCORE_MAX, 63), 0, none});
    rows.push_back('{mk_req(OP_LOOKUP, '0, 64'h8000_0000_0000_0000, 64, 0, SCORE_MAX,
                            0, 0), 1, mk_resp(1, SCORE_MAX, 1, 63)});
    // A different key on the same entry evicts the empty-board position.
    rows.push_back('{mk_req(OP_STORE, partner.pb, partner.ob, 0, 0, 0, 0, 9), 0, none});
    rows.push_back('{mk_req(OP_LOOKUP, '0, '0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk_req(OP_LOOKUP, partner.pb, partner.ob, 0, 0, 0, 0, 0), 0, none});

    while (rst) @(posedge clk);
    foreach (rows[k]) begin
      row = rows[k];
      offer_item(row.req, row.typed, row.want);
    end

    // Pool of positions in colliding pairs, so keys match and entries evict.
    for (int k = 0; k < 8; k++) begin
      pool[k].pb  = {$urandom, $urandom};
      pool[k].ob  = {$urandom, $urandom};
      pool[k + 8] = flip_word(flip_word(pool[k], pair_i), pair_j);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 4) != 0) begin
        pos = pool[$urandom_range(0, 15)];
      end else begin
        pos.pb = {$urandom, $urandom};
        pos.ob = {$urandom, $urandom};
      end
      r.op    = $urandom_range(0, 1) ? OP_STORE : OP_LOOKUP;
      r.pb    = pos.pb;
      r.ob    = pos.ob;
      if ($urandom_range(0, 9) == 0) r.depth = 7'($urandom_range(0, 127));
      else r.depth = 7'($urandom_range(0, 12));
      r.move  = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 7) == 0) begin
        // Full-range window and score.
        r.alpha = 21'($urandom);
        r.beta  = 21'($urandom);
        r.score = 21'($urandom);
      end else begin
        // Narrow window so that bounds decide often; sometimes inverted.
        a       = int'($urandom_range(0, 80)) - 40;
        r.alpha = 21'(a);
        r.beta  = 21'(a + int'($urandom_range(0, 60)) - 10);
        r.score = 21'(int'($urandom_range(0, 100)) - 50);
      end
      offer_item(r, 1'b0, none);
    end
    s_tvalid <= 1'b0;

    // Drain, then give the unit time to show any extra beat.
    while (lookup_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (lookup_expect_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", lookup_expect_q.size()));

    $display("Run: %0d items (%0d lookups, %0d stores), %0d directed, one long receiver hold",
             items_sent, lookups_sent, stores_sent, rows.size());
    $display("Results: %0d beats, %0d hits, %0d key matches, %0d mismatches",
             beats_taken, hits_seen, matches_seen, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
